### hdl/vr_pkg.sv
// ---------------------------------------------------------------------------
// vr_pkg
// Shared widths and constants for the vector refraction pipeline.
// ---------------------------------------------------------------------------
package vr_pkg;

	localparam int COMPONENT_BITS_DEF = 16;
	localparam int WORK_BITS          = 16;
	localparam int IDX_W              = 15;

	// working dot product, Q.16; |cw| <= 3 * 2^18
	localparam int CW_W      = 21;
	// index ratio, Q.16, clamped to 16.0
	localparam int NW_W      = 21;
	localparam int NW_SAT    = 1 << 20;
	localparam int DIV_STEPS = NW_W;
	localparam int DREM_W    = IDX_W + 1;

	localparam int C2_W   = 24;
	localparam int N2_W   = 25;
	localparam int DIFF_W = 25;
	localparam int PROD_W = N2_W + 1 + DIFF_W;
	localparam int R_W    = PROD_W - WORK_BITS + 1;
	localparam int NC_W   = 25;

	localparam int RAD_W  = 48;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 4;

	localparam int T_W = 27;

endpackage

### hdl/vector_refraction.sv
// ---------------------------------------------------------------------------
// vector_refraction
// Snell refraction of one ray direction, fully pipelined, one item a clock while the skid is empty.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle while the skid is empty; set by the 21-step restoring
// divider and the 24-step square root, each one step per register stage.
// A two-entry output buffer lets one more item enter while a result waits.
// Reset (arst_n low, async) clears all valid bits; the data path is not reset.
module vector_refraction #(
	parameter int COMPONENT_BITS = vr_pkg::COMPONENT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_from, index_to, zero pad
	input  logic [((6*COMPONENT_BITS+2*vr_pkg::IDX_W+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_x, out_y, out_z, zero pad
	output logic [((3*COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata,
	// blocked
	output logic m_axis_tuser
);
	import vr_pkg::*;

	localparam int B      = COMPONENT_BITS;
	localparam int F      = B - 2;
	localparam int IN_W   = ((6*B+2*IDX_W+7)/8)*8;
	localparam int OUT_W  = ((3*B+7)/8)*8;
	localparam int PS_W   = 2*B + 2;
	localparam int ND_W   = NW_W + 1 + B;
	localparam int TM_W   = T_W + B;
	localparam int SUM_W  = TM_W + 1;
	localparam int SH_W   = SUM_W - WORK_BITS;

	logic en;
	logic skid_v_q, out_v_q;
	logic [3*B-1:0] out_d_q, skid_d_q;
	logic out_b_q, skid_b_q;

	assign en = ~skid_v_q;
	assign s_axis_tready = en;

	// ---------------- stage 1: products ----------------
	logic v_s1;
	logic signed [2*B-1:0] p_s1 [3];
	logic [6*B-1:0] vec_s1;
	logic [IDX_W-1:0] from_s1, to_s1;
	logic sat_s1;
	logic [IDX_W-1:0] in_from, in_to;
	logic [IN_W-1:0] unused_in;

	assign in_from = s_axis_tdata[6*B +: IDX_W];
	assign in_to   = s_axis_tdata[6*B+IDX_W +: IDX_W];
	assign unused_in = s_axis_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= $signed(s_axis_tdata[i*B +: B]) * $signed(s_axis_tdata[(i+3)*B +: B]);
			end
			vec_s1  <= s_axis_tdata[6*B-1:0];
			from_s1 <= in_from;
			to_s1   <= in_to;
			// quotient above 16.0
			sat_s1  <= {5'b0, in_from, 16'b0} >= ({1'b0, in_to, 20'b0} + 36'(in_to));
		end
	end

	// ---------------- stage 2: dot product ----------------
	logic signed [PS_W-1:0] psum, c_full;
	logic signed [CW_W-1:0] cw_c;

	assign psum   = p_s1[0] + p_s1[1] + p_s1[2];
	assign c_full = psum >>> F;

	generate
		if (F >= WORK_BITS) begin : g_cw_dn
			assign cw_c = CW_W'(c_full >>> (F - WORK_BITS));
		end else begin : g_cw_up
			assign cw_c = CW_W'(c_full <<< (WORK_BITS - F));
		end
	endgenerate

	logic                   dv_v   [DIV_STEPS+1];
	logic [DREM_W-1:0]      dv_rem [DIV_STEPS+1];
	logic [NW_W-1:0]        dv_q   [DIV_STEPS+1];
	logic [NW_W-1:0]        dv_dd  [DIV_STEPS+1];
	logic [IDX_W-1:0]       dv_to  [DIV_STEPS+1];
	logic [6*B-1:0]         dv_vec [DIV_STEPS+1];
	logic signed [CW_W-1:0] dv_cw  [DIV_STEPS+1];
	logic                   dv_sat [DIV_STEPS+1];
	logic                   dv_blk [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem[0] <= DREM_W'(from_s1[IDX_W-1:5]);
			dv_q[0]   <= '0;
			dv_dd[0]  <= {from_s1[4:0], 16'b0};
			dv_to[0]  <= to_s1;
			dv_vec[0] <= vec_s1;
			dv_cw[0]  <= cw_c;
			dv_sat[0] <= sat_s1;
			dv_blk[0] <= (to_s1 == '0) || (cw_c == '0);
		end
	end

	// ---------------- restoring divider, one quotient bit per stage ----------------
	genvar j;
	generate
		for (j = 0; j < DIV_STEPS; j++) begin : g_div
			logic [DREM_W-1:0] nxt;
			logic ge;

			assign nxt = {dv_rem[j][DREM_W-2:0], dv_dd[j][DIV_STEPS-1-j]};
			assign ge  = nxt >= {1'b0, dv_to[j]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v[j+1] <= 1'b0;
				end else if (en) begin
					dv_v[j+1] <= dv_v[j];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem[j+1] <= ge ? nxt - {1'b0, dv_to[j]} : nxt;
					dv_q[j+1]   <= dv_q[j] | (NW_W'(ge) << (DIV_STEPS-1-j));
					dv_dd[j+1]  <= dv_dd[j];
					dv_to[j+1]  <= dv_to[j];
					dv_vec[j+1] <= dv_vec[j];
					dv_cw[j+1]  <= dv_cw[j];
					dv_sat[j+1] <= dv_sat[j];
					dv_blk[j+1] <= dv_blk[j];
				end
			end
		end
	endgenerate

	// ---------------- stage A: squares and scaled terms ----------------
	logic [NW_W-1:0] nw;
	logic signed [NW_W:0] nw_s;
	logic signed [2*CW_W-1:0] cw_sq;
	logic [2*NW_W-1:0] nw_sq;
	logic signed [NW_W+CW_W:0] nwcw;

	assign nw    = dv_sat[DIV_STEPS] ? NW_W'(NW_SAT) : dv_q[DIV_STEPS];
	assign nw_s  = $signed({1'b0, nw});
	assign cw_sq = dv_cw[DIV_STEPS] * dv_cw[DIV_STEPS];
	assign nw_sq = nw * nw;
	assign nwcw  = nw_s * dv_cw[DIV_STEPS];

	logic v_sa, cwp_sa, blk_sa;
	logic [C2_W-1:0] c2_sa;
	logic [N2_W-1:0] n2_sa;
	logic signed [NC_W-1:0] nc_sa;
	logic signed [ND_W-1:0] nd_sa [3];
	logic [3*B-1:0] m_sa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
		end else if (en) begin
			v_sa <= dv_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c2_sa  <= cw_sq[C2_W+WORK_BITS-1:WORK_BITS];
			n2_sa  <= nw_sq[N2_W+WORK_BITS-1:WORK_BITS];
			nc_sa  <= nwcw[NC_W+WORK_BITS-1:WORK_BITS];
			for (int i = 0; i < 3; i++) begin
				nd_sa[i] <= nw_s * $signed(dv_vec[DIV_STEPS][i*B +: B]);
			end
			m_sa   <= dv_vec[DIV_STEPS][6*B-1:3*B];
			cwp_sa <= ~dv_cw[DIV_STEPS][CW_W-1];
			blk_sa <= dv_blk[DIV_STEPS];
		end
	end

	// ---------------- stage B: n^2 * (1 - c^2) ----------------
	logic signed [DIFF_W-1:0] diff;
	assign diff = DIFF_W'(1 << WORK_BITS) - $signed({1'b0, c2_sa});

	logic v_sb, cwp_sb, blk_sb;
	logic signed [PROD_W-1:0] prod_sb;
	logic signed [NC_W-1:0] nc_sb;
	logic signed [ND_W-1:0] nd_sb [3];
	logic [3*B-1:0] m_sb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sb <= 1'b0;
		end else if (en) begin
			v_sb <= v_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_sb <= $signed({1'b0, n2_sa}) * diff;
			nc_sb   <= nc_sa;
			nd_sb   <= nd_sa;
			m_sb    <= m_sa;
			cwp_sb  <= cwp_sa;
			blk_sb  <= blk_sa;
		end
	end

	// ---------------- stage C: radicand ----------------
	logic signed [R_W-1:0] r_c;
	assign r_c = R_W'(1 << WORK_BITS) - R_W'(prod_sb >>> WORK_BITS);

	logic                   sq_v    [ROOT_W+1];
	logic [RAD_W-1:0]       sq_rad  [ROOT_W+1];
	logic [REM_W-1:0]       sq_rem  [ROOT_W+1];
	logic [ROOT_W-1:0]      sq_root [ROOT_W+1];
	logic signed [NC_W-1:0] sq_nc   [ROOT_W+1];
	logic [3*ND_W-1:0]      sq_nd   [ROOT_W+1];
	logic [3*B-1:0]         sq_m    [ROOT_W+1];
	logic                   sq_cwp  [ROOT_W+1];
	logic                   sq_blk  [ROOT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= v_sb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad[0]  <= {r_c[31:0], 16'b0};
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_nc[0]   <= nc_sb;
			sq_nd[0]   <= {nd_sb[2], nd_sb[1], nd_sb[0]};
			sq_m[0]    <= m_sb;
			sq_cwp[0]  <= cwp_sb;
			sq_blk[0]  <= blk_sb || r_c[R_W-1] || (r_c == '0);
		end
	end

	// ---------------- square root, one result bit per stage ----------------
	generate
		for (j = 0; j < ROOT_W; j++) begin : g_sqrt
			logic [REM_W-1:0] cur, trial;
			logic ge;

			assign cur   = {sq_rem[j][REM_W-3:0], sq_rad[j][RAD_W-1-2*j -: 2]};
			assign trial = REM_W'({sq_root[j], 2'b01});
			assign ge    = cur >= trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sq_v[j+1] <= 1'b0;
				end else if (en) begin
					sq_v[j+1] <= sq_v[j];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					sq_rem[j+1]  <= ge ? cur - trial : cur;
					sq_root[j+1] <= {sq_root[j][ROOT_W-2:0], ge};
					sq_rad[j+1]  <= sq_rad[j];
					sq_nc[j+1]   <= sq_nc[j];
					sq_nd[j+1]   <= sq_nd[j];
					sq_m[j+1]    <= sq_m[j];
					sq_cwp[j+1]  <= sq_cwp[j];
					sq_blk[j+1]  <= sq_blk[j];
				end
			end
		end
	endgenerate

	// ---------------- stage D: normal scale ----------------
	logic signed [T_W-1:0] s_pos, t_c;
	assign s_pos = $signed({3'b0, sq_root[ROOT_W]});
	assign t_c   = (sq_cwp[ROOT_W] ? s_pos : -s_pos) - T_W'(sq_nc[ROOT_W]);

	logic v_sd, blk_sd;
	logic signed [T_W-1:0] t_sd;
	logic [3*ND_W-1:0] nd_sd;
	logic [3*B-1:0] m_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd <= 1'b0;
		end else if (en) begin
			v_sd <= sq_v[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_sd   <= t_c;
			nd_sd  <= sq_nd[ROOT_W];
			m_sd   <= sq_m[ROOT_W];
			blk_sd <= sq_blk[ROOT_W];
		end
	end

	// ---------------- stage E: t * normal ----------------
	logic v_se, blk_se;
	logic signed [TM_W-1:0] tm_se [3];
	logic [3*ND_W-1:0] nd_se;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_se <= 1'b0;
		end else if (en) begin
			v_se <= v_sd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				tm_se[i] <= t_sd * $signed(m_sd[i*B +: B]);
			end
			nd_se  <= nd_sd;
			blk_se <= blk_sd;
		end
	end

	// ---------------- stage F: sum, scale, saturate ----------------
	logic [B-1:0] o_c [3];

	always_comb begin
		logic signed [SUM_W-1:0] sum;
		logic signed [SH_W-1:0] sh;
		for (int i = 0; i < 3; i++) begin
			sum = SUM_W'($signed(nd_se[i*ND_W +: ND_W])) + SUM_W'(tm_se[i]);
			sh  = SH_W'(sum >>> WORK_BITS);
			if (blk_se) begin
				o_c[i] = '0;
			end else if (sh[SH_W-1:B-1] == '0 || sh[SH_W-1:B-1] == '1) begin
				o_c[i] = sh[B-1:0];
			end else if (sh[SH_W-1]) begin
				o_c[i] = {1'b1, {(B-1){1'b0}}};
			end else begin
				o_c[i] = {1'b0, {(B-1){1'b1}}};
			end
		end
	end

	logic v_sf, blk_sf;
	logic [3*B-1:0] o_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (en) begin
			v_sf <= v_se;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_sf   <= {o_c[2], o_c[1], o_c[0]};
			blk_sf <= blk_se;
		end
	end

	// ---------------- output register and skid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && m_axis_tready) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_sf;
			end
		end else if (v_sf && en) begin
			if (!out_v_q) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && m_axis_tready) begin
			if (skid_v_q) begin
				out_d_q <= skid_d_q;
				out_b_q <= skid_b_q;
			end else begin
				out_d_q <= o_sf;
				out_b_q <= blk_sf;
			end
		end else if (v_sf && en) begin
			if (!out_v_q) begin
				out_d_q <= o_sf;
				out_b_q <= blk_sf;
			end else begin
				skid_d_q <= o_sf;
				skid_b_q <= blk_sf;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = OUT_W'(out_d_q);
	assign m_axis_tuser  = out_b_q;

endmodule

### hdl/vr_checker.sv
// ---------------------------------------------------------------------------
// vr_checker
// Port-level checks for vector_refraction, bound to the top level.
// ---------------------------------------------------------------------------
module vr_checker #(
	parameter int COMPONENT_BITS = vr_pkg::COMPONENT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	// dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_from, index_to, zero pad
	input logic [((6*COMPONENT_BITS+2*vr_pkg::IDX_W+7)/8)*8-1:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	// out_x, out_y, out_z, zero pad
	input logic [((3*COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata,
	// blocked
	input logic m_axis_tuser
);
	import vr_pkg::*;

	logic unused_in;
	assign unused_in = s_axis_tvalid ^ (^s_axis_tdata);

	// blocked item carries a zero vector
	a_blocked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("blocked item with nonzero vector");

	// input side stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !$past(m_axis_tready))
		else $error("input stalled without a waiting result");

	// nothing leaves during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("output valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output item changed");

endmodule

bind vector_refraction vr_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_vr_checker (.*);

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Streams rays into vector_refraction and checks every refracted vector and
// blocked flag against a bit-accurate fixed-point Snell predictor. Directed
// corner rays come first, then mostly unit-length random rays, with random
// stalls on both sides, one long output hold-off and one drain pause.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = vr_pkg::COMPONENT_BITS_DEF;
	localparam int N_RANDOM = 1880;
	localparam int PAUSE_AT = 900;
	localparam int HOLD_AT = 300;
	localparam int HOLD_LEN = 150;
	localparam int QUIET_TAIL = 200;
	localparam longint LIMIT = 400000;

	typedef struct packed {
		logic [14:0] idx_to;
		logic [14:0] idx_from;
		logic signed [CB-1:0] nz, ny, nx, dz, dy, dx;
	} ray_t;

	typedef struct packed {
		logic blk;
		logic signed [CB-1:0] z, y, x;
	} refr_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [47:0] m_axis_tdata;
	logic m_axis_tuser;

	ray_t rays_pending[$];
	refr_t refr_expected[$];
	int n_total = 0;
	int n_sent = 0;
	int n_recv = 0;
	int errs = 0;
	longint cycles = 0;

	vector_refraction dut (.*);

	always #5 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [CB-1:0] clamp_q(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[CB-1:0];
	endfunction

	function automatic refr_t refract(ray_t a);
		refr_t o;
		longint d[3], m[3];
		longint dot, cw, nw, c2, n2, r, s, t;
		o = '0;
		d[0] = a.dx; d[1] = a.dy; d[2] = a.dz;
		m[0] = a.nx; m[1] = a.ny; m[2] = a.nz;
		dot = d[0]*m[0] + d[1]*m[1] + d[2]*m[2];
		cw = (dot >>> 14) * 4;
		if (a.idx_to == 0 || cw == 0) begin
			o.blk = 1;
			return o;
		end
		nw = (longint'(a.idx_from) << 16) / longint'(a.idx_to);
		if (nw > (longint'(16) << 16)) nw = longint'(16) << 16;
		c2 = (cw * cw) >>> 16;
		n2 = (nw * nw) >>> 16;
		r = 65536 - ((n2 * (65536 - c2)) >>> 16);
		if (r <= 0) begin
			o.blk = 1;
			return o;
		end
		s = longint'(int_sqrt(longint'(r) << 16));
		t = (cw > 0 ? s : -s) - ((nw * cw) >>> 16);
		o.x = clamp_q((nw*d[0] + t*m[0]) >>> 16);
		o.y = clamp_q((nw*d[1] + t*m[1]) >>> 16);
		o.z = clamp_q((nw*d[2] + t*m[2]) >>> 16);
		return o;
	endfunction

	task automatic push_ray(int dx, int dy, int dz, int nx, int ny, int nz, int fr, int to);
		ray_t a;
		a.dx = CB'(dx); a.dy = CB'(dy); a.dz = CB'(dz);
		a.nx = CB'(nx); a.ny = CB'(ny); a.nz = CB'(nz);
		a.idx_from = 15'(fr); a.idx_to = 15'(to);
		rays_pending.push_back(a);
		n_total++;
	endtask

	function automatic int rand_comp();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	task automatic unit_vec(output int x, output int y, output int z);
		real a, b, c, l;
		a = real'(int'($urandom_range(0, 2000)) - 1000);
		b = real'(int'($urandom_range(0, 2000)) - 1000);
		c = real'(int'($urandom_range(0, 2000)) - 1000);
		l = $sqrt(a*a + b*b + c*c);
		if (l < 1.0) begin
			a = 1.0; l = 1.0;
		end
		x = $rtoi(a / l * 16383.0);
		y = $rtoi(b / l * 16383.0);
		z = $rtoi(c / l * 16383.0);
	endtask

	function automatic int rand_index();
		if ($urandom_range(0, 2) == 0) return int'($urandom_range(8192, 14000));
		return int'($urandom_range(8192, 32767));
	endfunction

	// driver
	always @(posedge clk) begin
		int idle;
		logic v;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				refr_expected.push_back(refract(rays_pending.pop_front()));
				n_sent++;
			end
			v = 0;
			if (s_axis_tvalid && !s_axis_tready) begin
				v = 1;
			end else if (idle > 0) begin
				idle--;
			end else if (rays_pending.size() != 0
				&& !(n_sent == PAUSE_AT && refr_expected.size() != 0)) begin
				if (n_sent < n_total - QUIET_TAIL && $urandom_range(0, 9) == 0)
					idle = $urandom_range(0, 6);
				else
					v = 1;
			end
			s_axis_tvalid <= v;
			if (v) s_axis_tdata <= {2'b00, rays_pending[0]};
		end else begin
			idle = 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		int stall;
		bit held;
		refr_t got, want;
		logic r;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tuser, m_axis_tdata[47:32], m_axis_tdata[31:16],
					m_axis_tdata[15:0]};
				n_recv++;
				if (refr_expected.size() == 0) begin
					$error("result with nothing expected");
					errs++;
				end else begin
					want = refr_expected.pop_front();
					if (got.x !== want.x) begin
						$error("out_x exp %0d got %0d", want.x, got.x); errs++;
					end
					if (got.y !== want.y) begin
						$error("out_y exp %0d got %0d", want.y, got.y); errs++;
					end
					if (got.z !== want.z) begin
						$error("out_z exp %0d got %0d", want.z, got.z); errs++;
					end
					if (got.blk !== want.blk) begin
						$error("blocked exp %0d got %0d", want.blk, got.blk); errs++;
					end
				end
			end
			r = 1;
			if (stall > 0) begin
				stall--;
				r = 0;
			end else if (!held && n_recv >= HOLD_AT) begin
				held = 1;
				stall = HOLD_LEN;
				r = 0;
			end else if (n_recv < n_total - QUIET_TAIL && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(0, 6);
				r = 0;
			end
			m_axis_tready <= r;
		end else begin
			stall = 0;
			held = 0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		int dx, dy, dz, nx, ny, nz;
		// unit normal incidence, equal indices
		push_ray(16384, 0, 0, 16384, 0, 0, 8192, 8192);
		push_ray(-16384, 0, 0, 16384, 0, 0, 8192, 8192);
		// glass to air at steep angle: total internal reflection
		push_ray(11585, 11585, 0, 16384, 0, 0, 12288, 8192);
		// grazing: orthogonal vectors and zero normal
		push_ray(0, 16384, 0, 16384, 0, 0, 8192, 12288);
		push_ray(16384, 16384, 16384, 0, 0, 0, 8192, 8192);
		push_ray(0, 0, 0, 0, 0, 0, 32767, 8192);
		// field extremes, saturation
		push_ray(32767, 32767, 32767, 32767, 32767, 32767, 32767, 8192);
		push_ray(-32768, -32768, -32768, -32768, -32768, -32768, 8192, 32767);
		push_ray(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767);
		push_ray(-32768, 32767, -32768, 32767, -32768, 32767, 8192, 8192);
		push_ray(32767, 0, 0, -32768, 0, 0, 32767, 8192);
		push_ray(-32768, 0, 0, -32768, 0, 0, 8192, 32767);
		// air into dense medium, oblique
		push_ray(11585, 11585, 0, 0, 16384, 0, 8192, 32767);
		push_ray(0, -11585, 11585, 0, 0, -16384, 8192, 12288);
		// tiny dot product, floor to zero and just off
		push_ray(1, 0, 0, 1, 0, 0, 8192, 8192);
		push_ray(-1, 0, 0, 1, 0, 0, 8192, 8192);
		push_ray(128, 0, 0, 128, 0, 0, 8192, 8192);
		push_ray(16384, 0, 0, 0, 0, 16384, 16384, 8192);
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				unit_vec(dx, dy, dz);
				unit_vec(nx, ny, nz);
				push_ray(dx, dy, dz, nx, ny, nz, rand_index(), rand_index());
			end else begin
				push_ray(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
					rand_comp(), rand_index(), rand_index());
			end
		end
		repeat (4) @(posedge clk);
		arst_n <= 1;
		wait (rays_pending.size() == 0 && refr_expected.size() == 0);
		repeat (80) @(posedge clk);
		if (errs == 0 && refr_expected.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
